// File: rtl/core/cab_pkg.sv
// Package for the clipped alpha image blit core: widths, codes and register
// indexes shared by the core. No dependencies.
`default_nettype none

package cab_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int ADDR_W  = 24;
  localparam int PIX_W   = 24;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 3;

  localparam logic [1:0] FMT_BGRA = 2'd0;
  localparam logic [1:0] FMT_RGB  = 2'd1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_PIXEL  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_BAD_FORMAT = 2'd2
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WINDOW_WIDTH  = 3'd0,
    REG_WINDOW_HEIGHT = 3'd1,
    REG_BORDER_LEFT   = 3'd2,
    REG_BORDER_TOP    = 3'd3,
    REG_IMAGE_WIDTH   = 3'd4,
    REG_IMAGE_HEIGHT  = 3'd5,
    REG_IMAGE_FORMAT  = 3'd6
  } reg_idx_t;

endpackage

`default_nettype wire

// File: rtl/core/clipped_alpha_image_blit_core.sv
// Clipped alpha image blit core: rectangle clipping, raster walk and BGRA/RGB
// pixel blend into 24-bit framebuffer writes. Depends on cab_pkg.
// An accepted input word passes through an input register and then a result
// register, the two stages. Throughput: one input word per cycle unless
// stalled; both are held while a result is pending and out_stall is high.
// Reset (rst_n low, synchronous): idle, no result pending, registers at
// their documented reset values.
`default_nettype none

module clipped_alpha_image_blit_core
  import cab_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                cfg_we,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_cmd,
  input  wire logic [DIM_W-1:0]    in_rect_x,
  input  wire logic [DIM_W-1:0]    in_rect_y,
  input  wire logic [DIM_W-1:0]    in_rect_w,
  input  wire logic [DIM_W-1:0]    in_rect_h,
  input  wire logic [7:0]          in_byte0,
  input  wire logic [7:0]          in_byte1,
  input  wire logic [7:0]          in_byte2,
  input  wire logic [7:0]          in_byte3,
  input  wire logic [PIX_W-1:0]    in_dest_pixel,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_kind,
  output logic                     out_write_enable,
  output logic [ADDR_W-1:0]        out_address,
  output logic [PIX_W-1:0]         out_pixel_value,
  output logic [DIM_W-1:0]         out_clipped_w,
  output logic [DIM_W-1:0]         out_clipped_h,
  output logic [1:0]               out_status,
  output logic                     out_last
);

  function automatic logic [7:0] blend(input logic [7:0] o, input logic [7:0] n,
                                       input logic [7:0] a);
    logic [15:0] acc;
    logic [15:0] q;
    logic [8:0]  avg;
    begin
      acc = 16'(o * (8'hFF - a)) + 16'(n * a);
      q   = 16'((17'(acc) + 17'd1 + 17'(acc[15:8])) >> 8);
      avg = {1'b0, o} + {1'b0, n};
      if (a == 8'hFF) begin
        blend = n;
      end else if (a == 8'h80) begin
        blend = avg[8:1];
      end else begin
        blend = q[7:0];
      end
    end
  endfunction

  // configuration
  logic [DIM_W-1:0] win_w_r, win_h_r, img_w_r, img_h_r;
  logic [7:0]       bord_l_r, bord_t_r;
  logic [1:0]       img_fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r   <= DIM_W'(640);
      win_h_r   <= DIM_W'(480);
      bord_l_r  <= '0;
      bord_t_r  <= '0;
      img_w_r   <= DIM_W'(1);
      img_h_r   <= DIM_W'(1);
      img_fmt_r <= FMT_BGRA;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WINDOW_WIDTH:  win_w_r   <= cfg_data;
        REG_WINDOW_HEIGHT: win_h_r   <= cfg_data;
        REG_BORDER_LEFT:   bord_l_r  <= cfg_data[7:0];
        REG_BORDER_TOP:    bord_t_r  <= cfg_data[7:0];
        REG_IMAGE_WIDTH:   img_w_r   <= cfg_data;
        REG_IMAGE_HEIGHT:  img_h_r   <= cfg_data;
        REG_IMAGE_FORMAT:  img_fmt_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic             s1_valid_r;
  logic             s1_cmd_r;
  logic [DIM_W-1:0] s1_x_r, s1_y_r, s1_w_r, s1_h_r;
  logic [7:0]       s1_b0_r, s1_b1_r, s1_b2_r, s1_b3_r;
  logic [PIX_W-1:0] s1_dp_r;

  logic advance;
  logic s1_load;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cmd_r <= in_cmd;
      s1_x_r   <= in_rect_x;
      s1_y_r   <= in_rect_y;
      s1_w_r   <= in_rect_w;
      s1_h_r   <= in_rect_h;
      s1_b0_r  <= in_byte0;
      s1_b1_r  <= in_byte1;
      s1_b2_r  <= in_byte2;
      s1_b3_r  <= in_byte3;
      s1_dp_r  <= in_dest_pixel;
    end
  end

  // blit state
  logic              busy_r, busy_nxt;
  logic [DIM_W-1:0]  org_r, org_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [DIM_W-1:0]  wl_r, wl_nxt, hl_r, hl_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt, row_r, row_nxt;

  // start path
  logic signed [DIM_W+1:0] x_s, y_s, ww_s, wh_s;
  logic                    outside;
  logic [DIM_W-1:0]        w_a, h_a, w_c, h_c;
  logic [DIM_W:0]          sum_w, sum_h;
  logic                    empty;
  status_t                 st;
  logic [2*DIM_W-1:0]      y_prod;

  always_comb begin
    x_s  = $signed({{2{s1_x_r[DIM_W-1]}}, s1_x_r}) + $signed({7'd0, bord_l_r});
    y_s  = $signed({{2{s1_y_r[DIM_W-1]}}, s1_y_r}) + $signed({7'd0, bord_t_r});
    ww_s = $signed({2'b00, win_w_r});
    wh_s = $signed({2'b00, win_h_r});
    outside = (x_s < 0) || (y_s < 0) || (x_s >= ww_s) || (y_s >= wh_s);
    w_a = (s1_w_r > img_w_r) ? img_w_r : s1_w_r;
    h_a = (s1_h_r > img_h_r) ? img_h_r : s1_h_r;
    sum_w = {1'b0, x_s[DIM_W-1:0]} + {1'b0, w_a};
    sum_h = {1'b0, y_s[DIM_W-1:0]} + {1'b0, h_a};
    w_c = (sum_w > {1'b0, win_w_r}) ? (win_w_r - x_s[DIM_W-1:0]) : w_a;
    h_c = (sum_h > {1'b0, win_h_r}) ? (win_h_r - y_s[DIM_W-1:0]) : h_a;
    empty = outside || (w_c == '0) || (h_c == '0);
    if (empty) begin
      st = ST_EMPTY;
    end else if (img_fmt_r != FMT_BGRA && img_fmt_r != FMT_RGB) begin
      st = ST_BAD_FORMAT;
    end else begin
      st = ST_OK;
    end
    y_prod = y_s[DIM_W-1:0] * win_w_r;
  end

  // pixel path
  logic [DIM_W-1:0]  iw_eff;
  logic              in_region, fin, wrap;
  logic [DIM_W-1:0]  col_inc, row_inc;
  logic [ADDR_W-1:0] addr;
  logic [PIX_W-1:0]  pix;
  logic              we;

  always_comb begin
    if (img_w_r == '0) begin
      iw_eff = DIM_W'(1);
    end else if (img_w_r > DIM_W'(MAX_DIM)) begin
      iw_eff = DIM_W'(MAX_DIM);
    end else begin
      iw_eff = img_w_r;
    end
    in_region = (col_r < wl_r) && (row_r < hl_r);
    fin = (col_r == wl_r - 1'b1) && (row_r == hl_r - 1'b1);
    col_inc = col_r + 1'b1;
    row_inc = row_r + 1'b1;
    wrap = col_inc >= iw_eff;
    addr = row_base_r + ADDR_W'(org_r) + ADDR_W'(col_r);
    we = 1'b1;
    if (img_fmt_r == FMT_RGB) begin
      pix = {s1_b0_r, s1_b1_r, s1_b2_r};
    end else if (s1_b3_r == 8'h00) begin
      we  = 1'b0;
      pix = s1_dp_r;
    end else begin
      pix = {blend(s1_dp_r[23:16], s1_b2_r, s1_b3_r),
             blend(s1_dp_r[15:8],  s1_b1_r, s1_b3_r),
             blend(s1_dp_r[7:0],   s1_b0_r, s1_b3_r)};
    end
  end

  logic s1_fire;
  assign s1_fire = s1_valid_r && advance;

  always_comb begin
    busy_nxt     = busy_r;
    org_nxt      = org_r;
    row_base_nxt = row_base_r;
    wl_nxt       = wl_r;
    hl_nxt       = hl_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (s1_fire) begin
      if (cmd_t'(s1_cmd_r) == CMD_START) begin
        busy_nxt = (st == ST_OK);
        if (st == ST_OK) begin
          org_nxt      = x_s[DIM_W-1:0];
          row_base_nxt = y_prod[ADDR_W-1:0];
          wl_nxt       = w_c;
          hl_nxt       = h_c;
          col_nxt      = '0;
          row_nxt      = '0;
        end
      end else if (busy_r) begin
        if (in_region && fin) begin
          busy_nxt = 1'b0;
        end else if (wrap) begin
          col_nxt      = '0;
          row_nxt      = row_inc;
          row_base_nxt = row_base_r + ADDR_W'(win_w_r);
          if (row_inc >= hl_r) begin
            busy_nxt = 1'b0;
          end
        end else begin
          col_nxt = col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      org_r      <= '0;
      row_base_r <= '0;
      wl_r       <= '0;
      hl_r       <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      busy_r     <= busy_nxt;
      org_r      <= org_nxt;
      row_base_r <= row_base_nxt;
      wl_r       <= wl_nxt;
      hl_r       <= hl_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

  // result stage
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  logic              we_r, we_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [PIX_W-1:0]  pix_r, pix_nxt;
  logic [DIM_W-1:0]  cw_r, cw_nxt, ch_r, ch_nxt;
  status_t           st_r, st_nxt;
  logic              last_r, last_nxt;

  always_comb begin
    out_valid_nxt = 1'b0;
    kind_nxt      = KIND_STATUS;
    we_nxt        = 1'b0;
    addr_nxt      = '0;
    pix_nxt       = '0;
    cw_nxt        = '0;
    ch_nxt        = '0;
    st_nxt        = ST_OK;
    last_nxt      = 1'b0;
    if (cmd_t'(s1_cmd_r) == CMD_START) begin
      out_valid_nxt = s1_valid_r;
      st_nxt        = st;
      if (!empty) begin
        cw_nxt = w_c;
        ch_nxt = h_c;
      end
    end else begin
      out_valid_nxt = s1_valid_r && busy_r && in_region;
      kind_nxt      = KIND_PIXEL;
      we_nxt        = we;
      addr_nxt      = addr;
      pix_nxt       = pix;
      cw_nxt        = wl_r;
      ch_nxt        = hl_r;
      last_nxt      = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r <= kind_nxt;
      we_r   <= we_nxt;
      addr_r <= addr_nxt;
      pix_r  <= pix_nxt;
      cw_r   <= cw_nxt;
      ch_r   <= ch_nxt;
      st_r   <= st_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_write_enable = we_r;
  assign out_address      = addr_r;
  assign out_pixel_value  = pix_r;
  assign out_clipped_w    = cw_r;
  assign out_clipped_h    = ch_r;
  assign out_status       = st_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire
